// ----- sv/mst_pkg.sv -----
// shared types and constants of the multi-slot timer service
// no dependencies
`default_nettype none

package mst_pkg;

    localparam int SLOT_W = 4;
    localparam int TICK_W = 32;

    // input item kinds
    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_STOP    = 3'd1;
    localparam logic [2:0] KIND_DELETE  = 3'd2;
    localparam logic [2:0] KIND_SERVICE = 3'd3;
    localparam logic [2:0] KIND_NEXT    = 3'd4;
    localparam logic [2:0] KIND_ACTIVE  = 3'd5;

    // result kinds
    localparam logic [2:0] RK_ACK     = 3'd0;
    localparam logic [2:0] RK_EXPIRED = 3'd1;
    localparam logic [2:0] RK_DONE    = 3'd2;
    localparam logic [2:0] RK_NEXT    = 3'd3;
    localparam logic [2:0] RK_ACTIVE  = 3'd4;

    localparam logic [TICK_W-1:0] NONE_LEFT = 32'hffff_ffff;

    // queued command kind field (low two bits of the input kind)
    localparam logic [1:0] QK_START = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_LINK,
        S_WRAP,
        S_DUE
    } t_state;

    // one result word from the back end
    typedef struct packed {
        logic              valid;
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result;

    // list heads seen by the front end
    typedef struct packed {
        logic              cur_busy;
        logic              oth_busy;
        logic [TICK_W-1:0] cur_head;
        logic [TICK_W-1:0] oth_head;
    } t_lstat;

endpackage

`default_nettype wire

// ----- sv/mst_cmd_queue.sv -----
// command fifo between front end and list engine
// depends on mst_pkg
`default_nettype none

module mst_cmd_queue
    import mst_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [2*TICK_W-1:0]            i_times,
    input  wire logic [SLOT_W+1:0]              i_ctl,
    input  wire logic                           i_pop,
    output logic [2*TICK_W-1:0]                 o_times,
    output logic [SLOT_W+1:0]                   o_ctl,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [2*TICK_W-1:0] r_mem_t [DEPTH];
    logic [SLOT_W+1:0]   r_mem_c [DEPTH];
    logic [PW-1:0]       r_wp, r_rp;
    logic [CW-1:0]       r_cnt;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem_t[r_wp] <= i_times;
            r_mem_c[r_wp] <= i_ctl;
        end
        if (i_pop) begin
            o_times <= r_mem_t[r_rp];
            o_ctl   <= r_mem_c[r_rp];
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_count = r_cnt;

endmodule

`default_nettype wire

// ----- sv/mst_engine.sv -----
// list engine: drains queued commands, keeps the two sorted expiry lists
// and fires expired slots; depends on mst_pkg
`default_nettype none

module mst_engine
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_go,
    input  wire logic                             i_wrap,
    input  wire logic [TICK_W-1:0]                i_now,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] i_q_count,
    input  wire logic [2*TICK_W-1:0]              i_q_times,
    input  wire logic [SLOT_W+1:0]                i_q_ctl,
    output logic                                  o_q_pop,
    output logic                                  o_busy,
    output t_result                               o_res,
    output t_lstat                                o_stat,
    output logic [NUM_SLOTS-1:0]                  o_linked
);

    localparam int LW = $clog2(NUM_SLOTS+1);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_ord [2][NUM_SLOTS];
    logic [SLOT_W-1:0]   n_ord [2][NUM_SLOTS];
    logic [TICK_W-1:0]   r_exp [2][NUM_SLOTS];
    logic [TICK_W-1:0]   n_exp [2][NUM_SLOTS];
    logic [LW-1:0]       r_len [2];
    logic [LW-1:0]       n_len [2];
    logic                r_cur, n_cur;
    logic                r_wrap, n_wrap;
    logic [TICK_W-1:0]   r_now, n_now;
    logic [NUM_SLOTS-1:0] r_linked, n_linked;
    logic                r_pl, n_pl;
    logic [SLOT_W-1:0]   r_ps, n_ps;
    logic [TICK_W-1:0]   r_pe, n_pe;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_cur    <= 1'b0;
            r_wrap   <= 1'b0;
            r_linked <= '0;
        end else begin
            r_state  <= n_state;
            r_len[0] <= n_len[0];
            r_len[1] <= n_len[1];
            r_cur    <= n_cur;
            r_wrap   <= n_wrap;
            r_linked <= n_linked;
        end
    end

    // list contents and pending link
    always_ff @(posedge i_clk) begin
        r_ord <= n_ord;
        r_exp <= n_exp;
        r_now <= n_now;
        r_pl  <= n_pl;
        r_ps  <= n_ps;
        r_pe  <= n_pe;
    end

    // sequencer, unlink and sorted insert
    always_comb begin
        logic              v_un;
        logic [SLOT_W-1:0] v_us;
        logic              v_in;
        logic              v_seen;
        logic              v_prev;
        logic              v_ins;
        logic [TICK_W-1:0] v_mark;
        logic [TICK_W-1:0] v_tmo;
        logic [TICK_W-1:0] v_nx;
        logic              v_fire;

        n_state  = r_state;
        n_ord    = r_ord;
        n_exp    = r_exp;
        n_len[0] = r_len[0];
        n_len[1] = r_len[1];
        n_cur    = r_cur;
        n_wrap   = r_wrap;
        n_now    = r_now;
        n_linked = r_linked;
        n_pl     = r_pl;
        n_ps     = r_ps;
        n_pe     = r_pe;
        o_q_pop  = 1'b0;
        o_res    = '0;
        v_un     = 1'b0;
        v_us     = '0;
        v_in     = 1'b0;
        v_seen   = 1'b0;
        v_prev   = 1'b0;
        v_ins    = 1'b0;
        v_mark   = i_q_times[TICK_W-1:0];
        v_tmo    = i_q_times[2*TICK_W-1:TICK_W];
        v_nx     = v_mark + v_tmo;
        v_fire   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_wrap  = i_wrap;
                    n_now   = i_now;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_q_count != '0) begin
                    o_q_pop = 1'b1;
                    n_state = S_EXEC;
                end else begin
                    n_state = S_WRAP;
                end
            end
            S_EXEC: begin
                n_state = S_FETCH;
                if ({28'd0, i_q_ctl[SLOT_W-1:0]} < 32'(NUM_SLOTS)) begin
                    v_un = 1'b1;
                    v_us = i_q_ctl[SLOT_W-1:0];
                    if (i_q_ctl[SLOT_W+1:SLOT_W] == QK_START) begin
                        if (v_nx <= r_now) begin
                            v_fire = (r_now - v_mark) >= v_tmo;
                            n_pl   = ~r_cur;
                        end else begin
                            v_fire = (r_now < v_mark) && (v_nx >= v_mark);
                            n_pl   = r_cur;
                        end
                        n_ps = i_q_ctl[SLOT_W-1:0];
                        n_pe = v_nx;
                        if (v_fire) begin
                            o_res = '{valid: 1'b1, kind: RK_EXPIRED,
                                      slot: i_q_ctl[SLOT_W-1:0], last: 1'b0};
                        end else begin
                            n_state = S_LINK;
                        end
                    end
                end
            end
            S_LINK: begin
                v_in    = 1'b1;
                n_state = S_FETCH;
            end
            S_WRAP: begin
                if (r_wrap && r_len[r_cur] != '0) begin
                    v_un  = 1'b1;
                    v_us  = r_ord[r_cur][0];
                    o_res = '{valid: 1'b1, kind: RK_EXPIRED, slot: r_ord[r_cur][0],
                              last: 1'b0};
                end else begin
                    n_cur   = r_cur ^ r_wrap;
                    n_state = S_DUE;
                end
            end
            S_DUE: begin
                if (r_len[r_cur] != '0 && r_exp[r_cur][0] <= r_now) begin
                    v_un  = 1'b1;
                    v_us  = r_ord[r_cur][0];
                    o_res = '{valid: 1'b1, kind: RK_EXPIRED, slot: r_ord[r_cur][0],
                              last: 1'b0};
                end else begin
                    o_res   = '{valid: 1'b1, kind: RK_DONE, slot: '0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // unlink: close the gap behind the matching entry in either list
        if (v_un) begin
            for (int l = 0; l < 2; l++) begin
                v_seen = 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (i < int'(r_len[l]) && r_ord[l][i] == v_us) begin
                        v_seen = 1'b1;
                    end
                    if (v_seen && i + 1 < NUM_SLOTS) begin
                        n_ord[l][i] = r_ord[l][(i+1) % NUM_SLOTS];
                        n_exp[l][i] = r_exp[l][(i+1) % NUM_SLOTS];
                    end
                end
                if (v_seen) begin
                    n_len[l] = r_len[l] - 1'b1;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (32'(v_us) == i) begin
                    n_linked[i] = 1'b0;
                end
            end
        end

        // insert behind every entry with the same or an earlier expiry
        if (v_in && int'(r_len[r_pl]) < NUM_SLOTS) begin
            v_prev = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                v_ins = (i < int'(r_len[r_pl]) && r_exp[r_pl][i] > r_pe)
                      || i == int'(r_len[r_pl]);
                if (i <= int'(r_len[r_pl])) begin
                    if (v_prev) begin
                        n_ord[r_pl][i] = r_ord[r_pl][(i+NUM_SLOTS-1) % NUM_SLOTS];
                        n_exp[r_pl][i] = r_exp[r_pl][(i+NUM_SLOTS-1) % NUM_SLOTS];
                    end else if (v_ins) begin
                        n_ord[r_pl][i] = r_ps;
                        n_exp[r_pl][i] = r_pe;
                    end
                end
                v_prev = v_ins;
            end
            n_len[r_pl] = r_len[r_pl] + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (32'(r_ps) == i) begin
                    n_linked[i] = 1'b1;
                end
            end
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_linked = r_linked;
    assign o_stat   = '{cur_busy: (r_len[r_cur] != '0),
                        oth_busy: (r_len[~r_cur] != '0),
                        cur_head: r_exp[r_cur][0],
                        oth_head: r_exp[~r_cur][0]};

endmodule

`default_nettype wire

// ----- sv/multi_slot_timer_service_core.sv -----
// top level of the multi-slot timer service: front end, command fifo,
// list engine and result register; depends on mst_pkg, mst_cmd_queue, mst_engine
`default_nettype none

// Commands (start, stop, delete) and queries are answered with one word on
// the cycle after start, and the block takes a new item every cycle for them
// while busy is low. A service item raises busy and walks the engine sequencer:
// it fetches and executes each queued command, links a start that has not
// expired, fires every slot left in the current list after a tick wrap, then
// every due slot, and ends with a done word. Every word appears for one cycle
// on o_strobe; the receiver cannot stall, and o_last marks the final word of each item.
module multi_slot_timer_service_core
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_kind,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [TICK_W-1:0] i_timeout,
    input  wire logic [TICK_W-1:0] i_now,
    output logic                   o_strobe,
    output logic [2:0]             o_result_kind,
    output logic [SLOT_W-1:0]      o_slot_out,
    output logic                   o_accepted,
    output logic                   o_active,
    output logic [TICK_W-1:0]      o_ticks_to_next,
    output logic                   o_last
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic                 w_acc;
    logic                 w_slot_ok;
    logic                 w_push;
    logic                 w_go;
    logic [CW-1:0]        w_q_count;
    logic [2*TICK_W-1:0]  w_q_times;
    logic [SLOT_W+1:0]    w_q_ctl;
    logic                 w_q_pop;
    logic                 w_eng_busy;
    t_result              w_res;
    t_lstat               w_stat;
    logic [NUM_SLOTS-1:0] w_linked;
    logic                 w_linked_bit;
    logic [TICK_W-1:0]    w_nx;
    logic [TICK_W-1:0]    w_ticks;
    logic [TICK_W-1:0]    r_last_tick;

    // front end classification
    assign w_acc     = start && !w_eng_busy;
    assign w_slot_ok = {28'd0, i_slot} < 32'(NUM_SLOTS);
    assign w_push    = w_acc && (i_kind == KIND_START || i_kind == KIND_STOP
                       || i_kind == KIND_DELETE) && w_slot_ok
                       && (w_q_count != CW'(QUEUE_DEPTH));
    assign w_go      = w_acc && (i_kind == KIND_SERVICE);
    assign busy      = w_eng_busy;

    mst_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_times ({i_timeout, i_now}),
        .i_ctl   ({i_kind[1:0], i_slot}),
        .i_pop   (w_q_pop),
        .o_times (w_q_times),
        .o_ctl   (w_q_ctl),
        .o_count (w_q_count)
    );

    mst_engine #(.NUM_SLOTS(NUM_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_wrap    (i_now < r_last_tick),
        .i_now     (i_now),
        .i_q_count (w_q_count),
        .i_q_times (w_q_times),
        .i_q_ctl   (w_q_ctl),
        .o_q_pop   (w_q_pop),
        .o_busy    (w_eng_busy),
        .o_res     (w_res),
        .o_stat    (w_stat),
        .o_linked  (w_linked)
    );

    // active bit of the addressed slot
    always_comb begin
        w_linked_bit = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (32'(i_slot) == i) begin
                w_linked_bit = w_linked[i];
            end
        end
    end

    // ticks to the nearest expiry
    always_comb begin
        w_nx    = w_stat.cur_busy ? w_stat.cur_head : w_stat.oth_head;
        w_ticks = w_nx - i_now;
        if (!w_stat.cur_busy && !w_stat.oth_busy) begin
            w_ticks = NONE_LEFT;
        end else if (w_nx <= i_now) begin
            if ((i_now - r_last_tick) >= (w_nx - r_last_tick)) begin
                w_ticks = '0;
            end
        end else if (i_now < r_last_tick && w_nx >= r_last_tick) begin
            w_ticks = '0;
        end
    end

    // last service tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick <= '0;
        end else if (w_go) begin
            r_last_tick <= i_now;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (w_acc && !w_go) || w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_kind   <= RK_ACK;
        o_slot_out      <= i_slot;
        o_accepted      <= 1'b0;
        o_active        <= 1'b0;
        o_ticks_to_next <= '0;
        o_last          <= 1'b1;
        if (w_res.valid) begin
            o_result_kind <= w_res.kind;
            o_slot_out    <= w_res.slot;
            o_last        <= w_res.last;
        end else if (i_kind == KIND_NEXT) begin
            o_result_kind   <= RK_NEXT;
            o_slot_out      <= '0;
            o_ticks_to_next <= w_ticks;
        end else if (i_kind == KIND_ACTIVE) begin
            o_result_kind <= RK_ACTIVE;
            o_active      <= w_slot_ok && w_linked_bit;
        end else begin
            o_accepted <= w_push;
        end
    end

`ifndef SYNTHESIS
    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc && w_res.valid))
        else $error("engine word collides with front end word");
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_kind == KIND_SERVICE))
        else $error("busy without service item");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == RK_DONE) |-> o_last)
        else $error("service done word not marked last");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= CW'(QUEUE_DEPTH))
        else $error("command queue overfilled");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(w_res.valid && w_res.kind == RK_DONE))
        else $error("service ended without done word");
`endif

endmodule

`default_nettype wire
